@@ hw/rtl/lss_pkg.sv @@
package lss_pkg;

  // default and field widths
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int PIX_W         = 8;
  localparam int CFG_W_BITS    = 12;
  localparam int CFG_H_BITS    = 16;
  localparam int APB_DW        = 32;
  localparam int APB_AW        = 3;
  localparam int OUT_DEPTH     = 4;

  localparam logic [CFG_W_BITS-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [CFG_H_BITS-1:0] RESET_HEIGHT = 16'd480;
  localparam logic [PIX_W-1:0]      PIX_MAX      = 8'd255;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  // control carried from the issue stage to the data stage
  typedef struct packed {
    logic             emit;
    logic             is_pixel;
    logic             interior;
    logic             last;
    logic             sel_recent;
    logic [PIX_W-1:0] pix;
  } lss_item_t;

  // one finished output pixel
  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] pix;
  } lss_res_t;

endpackage

@@ hw/rtl/laplacian_sharpen_stream.sv @@
// channel     | dir | handshake                        | payload
// ------------+-----+----------------------------------+------------------------------------
// pixel in    | in  | s_axis_tvalid / s_axis_tready    | tdata = pixel_in, tuser = cmd
// pixel out   | out | m_axis_tvalid / m_axis_tready    | tdata = pixel_out, tlast = last_of_frame
// config      | in  | psel / penable / pwrite / pready | paddr, pwdata, prdata (width 0x0, height 0x4)
//
// one item per clock while s_axis_tready is high; results pass the data and kernel registers
// the dual-port line store (older and recent rows in one word) is read once per item and
// written once per pixel, in the cycle after its read
// reset clears counters and the output buffer; the line store needs no clearing pass
// s_axis_tready drops when buffered results plus results in flight reach 4

module laplacian_sharpen_stream
  import lss_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave side
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel_in
  input  logic [0:0]            s_axis_tuser,   // [0] cmd
  // master side
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [PIX_W-1:0]      m_axis_tdata,   // [7:0] pixel_out
  output logic                  m_axis_tlast,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int PW   = $clog2(MAX_WIDTH + 2);
  localparam int HW   = CFG_H_BITS;
  localparam int MDW  = 2 * PIX_W;
  localparam int FCW  = $clog2(OUT_DEPTH + 1);
  localparam int OCW  = FCW + 1;

  // configuration
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic          cfg_clear;

  lss_cfg #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .eff_width_o  (eff_w),
    .eff_height_o (eff_h),
    .clear_o      (cfg_clear)
  );

  // issue stage: raster position of input and output, pending count
  logic [AW-1:0] in_col_q, in_col_d;
  logic [HW-1:0] in_row_q, in_row_d;
  logic [AW-1:0] out_col_q, out_col_d;
  logic [HW-1:0] out_row_q, out_row_d;
  logic [PW-1:0] pend_q, pend_d;

  logic          s_xfer;
  cmd_e          cmd;
  logic          is_pixel;
  logic          produce;
  logic          drain_emit;
  logic          emit;
  logic [PW-1:0] w_plus1;
  logic [WW-1:0] w_m1;
  logic [HW-1:0] h_m1;
  logic          in_col_end, in_row_end;
  logic          out_col_end, out_row_end;
  logic          out_interior;
  logic [AW-1:0] rd_addr;
  logic          fwd_d;
  lss_item_t     item_d;

  // data stage
  logic          s1_valid_q;
  lss_item_t     s1_item_q;
  logic [AW-1:0] s1_addr_q;
  logic          s1_fwd_q;
  logic [MDW-1:0] mem_rd_data;
  logic [MDW-1:0] cur_data;
  logic [MDW-1:0] wr_data;
  logic [MDW-1:0] last_wr_q;
  logic          mem_wr_en;

  // output side
  logic          res_valid;
  lss_res_t      res;
  lss_res_t      head;
  logic [FCW-1:0] fifo_cnt;
  logic [OCW-1:0] occupancy;

  assign s_xfer   = s_axis_tvalid && s_axis_tready;
  assign cmd      = cmd_e'(s_axis_tuser[0]);
  assign is_pixel = (cmd == CMD_PIXEL);

  assign w_plus1 = PW'(eff_w) + PW'(1);
  assign w_m1    = eff_w - WW'(1);
  assign h_m1    = eff_h - HW'(1);

  // a pixel produces once width+1 pixels are pending; a drain emits the oldest one
  assign produce    = s_xfer && is_pixel && (pend_q >= w_plus1);
  assign drain_emit = s_xfer && !is_pixel && (pend_q != '0);
  assign emit       = produce || drain_emit;

  assign in_col_end  = (WW'(in_col_q) == w_m1);
  assign in_row_end  = (in_row_q == h_m1);
  assign out_col_end = (WW'(out_col_q) == w_m1);
  assign out_row_end = (out_row_q == h_m1);

  // border rows and columns pass through
  assign out_interior = (out_row_q != '0) && (out_row_q < h_m1) &&
                        (out_col_q != '0) && (WW'(out_col_q) < w_m1);

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    pend_d    = pend_q;
    if (cfg_clear) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      pend_d    = '0;
    end else begin
      if (s_xfer && is_pixel) begin
        in_col_d = in_col_end ? '0 : in_col_q + AW'(1);
        if (in_col_end) begin
          in_row_d = in_row_end ? '0 : in_row_q + HW'(1);
        end
        if (!produce) begin
          pend_d = pend_q + PW'(1);
        end
      end
      if (drain_emit) begin
        pend_d = pend_q - PW'(1);
      end
      if (emit) begin
        out_col_d = out_col_end ? '0 : out_col_q + AW'(1);
        if (out_col_end) begin
          out_row_d = out_row_end ? '0 : out_row_q + HW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pend_q    <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      pend_q    <= pend_d;
    end
  end

  // pixels read their own column, drains read the oldest pending column
  assign rd_addr = is_pixel ? in_col_q : out_col_q;

  // the op in the data stage writes this cycle; a read of that column takes its data instead
  assign fwd_d = s1_valid_q && s1_item_q.is_pixel && (s1_addr_q == rd_addr);

  always_comb begin
    item_d.emit       = emit;
    item_d.is_pixel   = is_pixel;
    item_d.interior   = produce && out_interior;
    item_d.last       = out_col_end && out_row_end;
    item_d.sel_recent = (pend_q <= PW'(eff_w));
    item_d.pix        = s_axis_tdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      s1_item_q <= item_d;
      s1_addr_q <= rd_addr;
      s1_fwd_q  <= fwd_d;
    end
  end

  lss_line_mem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (s_xfer),
    .rd_addr_i (rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_data)
  );

  assign cur_data  = s1_fwd_q ? last_wr_q : mem_rd_data;
  // recent row moves to older, new pixel becomes recent
  assign wr_data   = {cur_data[PIX_W-1:0], s1_item_q.pix};
  assign mem_wr_en = s1_valid_q && s1_item_q.is_pixel;

  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      last_wr_q <= wr_data;
    end
  end

  lss_kernel u_kernel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_valid_i   (s1_valid_q),
    .s1_item_i    (s1_item_q),
    .cur_older_i  (cur_data[MDW-1:PIX_W]),
    .cur_recent_i (cur_data[PIX_W-1:0]),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  lss_out_fifo u_out_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (res_valid),
    .push_data_i   (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .head_o        (head),
    .count_o       (fifo_cnt)
  );

  assign m_axis_tdata = head.pix;
  assign m_axis_tlast = head.last;

  // credit check on registered state only: buffered plus both stages in flight
  assign occupancy = OCW'(fifo_cnt) + OCW'(s1_valid_q && s1_item_q.emit) + OCW'(res_valid);
  assign s_axis_tready = (occupancy < OCW'(OUT_DEPTH));

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= w_plus1)
    else $error("pending count above width plus one");

  a_fifo_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !(m_axis_tvalid && m_axis_tready)) |-> (fifo_cnt != FCW'(OUT_DEPTH)))
    else $error("result pushed into a full output buffer");

  a_fwd_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && is_pixel && fwd_d) |-> (eff_w == WW'(1)))
    else $error("pixel column collision with width above one");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (WW'(in_col_q) < eff_w) && (WW'(out_col_q) < eff_w))
    else $error("raster column outside the frame width");
`endif

endmodule

@@ hw/rtl/lss_cfg.sv @@
module lss_cfg
  import lss_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready,
  output logic [WW-1:0]         eff_width_o,
  output logic [CFG_H_BITS-1:0] eff_height_o,
  output logic                  clear_o
);

  localparam int CW = (WW > CFG_W_BITS) ? WW : CFG_W_BITS;

  logic [CFG_W_BITS-1:0] width_q, width_d;
  logic [CFG_H_BITS-1:0] height_q, height_d;
  logic                  wr;
  reg_idx_e              idx;
  logic [CW-1:0]         width_ext;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr) begin
      case (idx)
        REG_FRAME_WIDTH:  width_d  = pwdata[CFG_W_BITS-1:0];
        REG_FRAME_HEIGHT: height_d = pwdata[CFG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_WIDTH:  prdata = APB_DW'(width_q);
      REG_FRAME_HEIGHT: prdata = APB_DW'(height_q);
      default:          prdata = '0;
    endcase
  end

  // zero acts as one, anything above the line store acts as its size
  assign width_ext = CW'(width_q);
  always_comb begin
    if (width_q == '0) begin
      eff_width_o = WW'(1);
    end else if (width_ext > CW'(MAX_WIDTH)) begin
      eff_width_o = WW'(MAX_WIDTH);
    end else begin
      eff_width_o = WW'(width_ext);
    end
  end

  assign eff_height_o = (height_q == '0) ? CFG_H_BITS'(1) : height_q;
  assign clear_o      = wr;

endmodule

@@ hw/rtl/lss_line_mem.sv @@
module lss_line_mem
  import lss_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int AW = $clog2(MAX_WIDTH),
  localparam int DW = 2 * PIX_W
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  // one word per column: older row in the upper byte, recent row in the lower
  logic [DW-1:0] mem [MAX_WIDTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/lss_kernel.sv @@
module lss_kernel
  import lss_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s1_valid_i,
  input  lss_item_t        s1_item_i,
  input  logic [PIX_W-1:0] cur_older_i,
  input  logic [PIX_W-1:0] cur_recent_i,
  output logic             res_valid_o,
  output lss_res_t         res_o
);

  // column window of the last two pixel steps
  logic [PIX_W-1:0] r1_q, o1_q, p1_q, r2_q;

  logic             s2_valid_q;
  logic [PIX_W-1:0] s2_centre_q, s2_centre_d;
  logic [PIX_W-1:0] s2_lap_q, s2_lap_d;
  logic             s2_last_q;

  logic [PIX_W+1:0]        sum4;
  logic [PIX_W+1:0]        centre4;
  logic signed [PIX_W+2:0] diff;
  logic [PIX_W+2:0]        mag;
  logic [PIX_W:0]          out_sum;

  always_ff @(posedge clk_i) begin
    if (s1_valid_i && s1_item_i.is_pixel) begin
      r2_q <= r1_q;
      r1_q <= cur_recent_i;
      o1_q <= cur_older_i;
      p1_q <= s1_item_i.pix;
    end
  end

  // centre is the recent value of the previous column, or a raw store read on drain
  always_comb begin
    if (s1_item_i.is_pixel) begin
      s2_centre_d = r1_q;
    end else if (s1_item_i.sel_recent) begin
      s2_centre_d = cur_recent_i;
    end else begin
      s2_centre_d = cur_older_i;
    end
  end

  // top + bottom + left + right - 4 * centre
  assign sum4    = (PIX_W+2)'(o1_q) + (PIX_W+2)'(p1_q) + (PIX_W+2)'(r2_q)
                 + (PIX_W+2)'(cur_recent_i);
  assign centre4 = {r1_q, 2'b00};
  assign diff    = $signed({1'b0, sum4}) - $signed({1'b0, centre4});
  assign mag     = diff[PIX_W+2] ? (PIX_W+3)'(-diff) : (PIX_W+3)'(diff);

  always_comb begin
    if (!s1_item_i.interior) begin
      s2_lap_d = '0;
    end else if (mag > (PIX_W+3)'(PIX_MAX)) begin
      s2_lap_d = PIX_MAX;
    end else begin
      s2_lap_d = mag[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_i && s1_item_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_centre_q <= s2_centre_d;
    s2_lap_q    <= s2_lap_d;
    s2_last_q   <= s1_item_i.last;
  end

  assign out_sum     = (PIX_W+1)'(s2_centre_q) + (PIX_W+1)'(s2_lap_q[PIX_W-1:1]);
  assign res_valid_o = s2_valid_q;
  assign res_o.pix   = out_sum[PIX_W] ? PIX_MAX : out_sum[PIX_W-1:0];
  assign res_o.last  = s2_last_q;

endmodule

@@ hw/rtl/lss_out_fifo.sv @@
module lss_out_fifo
  import lss_pkg::*;
#(
  localparam int PTRW = $clog2(OUT_DEPTH),
  localparam int CNTW = $clog2(OUT_DEPTH + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lss_res_t        push_data_i,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output lss_res_t        head_o,
  output logic [CNTW-1:0] count_o
);

  lss_res_t        slots_q [OUT_DEPTH];
  logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] cnt_q;
  logic            pop;

  assign m_axis_tvalid = (cnt_q != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign head_o        = slots_q[rd_ptr_q];
  assign count_o       = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTRW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTRW'(1);
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + CNTW'(1);
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

endmodule
